[rtl/lg_pkg.sv]
// Shared types and constants for the Life generation step unit.
// Used by lg_front, lg_queue, lg_back and life_generation_step_unit.
`timescale 1ns / 1ps
`default_nettype none

package lg_pkg;

    localparam int ROW_W       = 64;  // cells per row
    localparam int WIDTH_W     = 7;   // grid_width register
    localparam int COUNT_W     = 4;   // neighbour count, 0..8
    localparam int QUEUE_DEPTH = 2;   // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] KEEP_COUNT  = COUNT_W'(2);

    // One row to evaluate, with its neighbour rows
    typedef struct packed {
        logic [ROW_W-1:0] upper;
        logic [ROW_W-1:0] middle;
        logic [ROW_W-1:0] lower;
        logic             done;
    } t_job;

    // Front status seen by the top level
    typedef struct packed {
        logic have_mid;
        logic flush_pend;
    } t_front_stat;

endpackage

`default_nettype wire

[rtl/lg_front.sv]
// Front part: accepts rows, keeps the two rows above and issues evaluation jobs.
// Depends on lg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lg_front import lg_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic             i_last,
    output logic                  o_push,
    output t_job                  o_job,
    input  wire logic             i_push_ready,
    output t_front_stat           o_stat
);

    logic [ROW_W-1:0] r_upper, n_upper;
    logic [ROW_W-1:0] r_middle, n_middle;
    logic             r_have_mid, n_have_mid;
    logic             r_flush_pend, n_flush_pend;
    logic             w_accept;

    assign o_ready  = !r_flush_pend && i_push_ready;
    assign w_accept = i_valid && o_ready;
    assign o_stat   = '{have_mid: r_have_mid, flush_pend: r_flush_pend};

    always_comb begin
        o_push = 1'b0;
        o_job  = '{upper: r_upper, middle: r_middle, lower: i_row, done: 1'b0};
        if (r_flush_pend) begin
            // bottom row of the frame, dead row below
            o_push = i_push_ready;
            o_job  = '{upper: r_upper, middle: r_middle, lower: '0, done: 1'b1};
        end else if (w_accept && r_have_mid) begin
            o_push = 1'b1;
        end else if (w_accept && i_last) begin
            // single-row grid
            o_push = 1'b1;
            o_job  = '{upper: '0, middle: i_row, lower: '0, done: 1'b1};
        end
    end

    always_comb begin
        n_upper      = r_upper;
        n_middle     = r_middle;
        n_have_mid   = r_have_mid;
        n_flush_pend = r_flush_pend;
        if (r_flush_pend) begin
            if (i_push_ready) begin
                n_flush_pend = 1'b0;
                n_have_mid   = 1'b0;
            end
        end else if (w_accept) begin
            if (!r_have_mid) begin
                n_upper    = '0;
                n_middle   = i_row;
                n_have_mid = !i_last;
            end else begin
                n_upper      = r_middle;
                n_middle     = i_row;
                n_flush_pend = i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_upper  <= n_upper;
        r_middle <= n_middle;
        if (!i_rst_n) begin
            r_have_mid   <= 1'b0;
            r_flush_pend <= 1'b0;
        end else begin
            r_have_mid   <= n_have_mid;
            r_flush_pend <= n_flush_pend;
        end
    end

endmodule

`default_nettype wire

[rtl/lg_queue.sv]
// Short job queue between the front and back parts.
// Depends on lg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lg_queue import lg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_push_ready,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_job        = r_mem[r_rd_ptr];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/lg_back.sv]
// Back part: applies B3/S23 to all columns of one job and holds the result row.
// Depends on lg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lg_back import lg_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_job             i_job,
    output logic                  o_pop,
    input  wire logic [ROW_W-1:0] i_col_mask,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [ROW_W-1:0]      o_cells,
    output logic                  o_done
);

    logic [ROW_W-1:0] r_cells;
    logic             r_done;
    logic             r_valid;
    logic [ROW_W-1:0] w_up, w_mid, w_low;
    logic [ROW_W-1:0] w_up_l, w_up_r, w_mid_l, w_mid_r, w_low_l, w_low_r;
    logic [ROW_W-1:0] n_cells;
    logic [COUNT_W-1:0] w_cnt [ROW_W];

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_cells = r_cells;
    assign o_done  = r_done;

    // Dead cells beyond the grid width
    assign w_up  = i_job.upper  & i_col_mask;
    assign w_mid = i_job.middle & i_col_mask;
    assign w_low = i_job.lower  & i_col_mask;

    // _l: neighbour at column c-1, _r: neighbour at column c+1
    assign w_up_l  = {w_up[ROW_W-2:0], 1'b0};
    assign w_up_r  = {1'b0, w_up[ROW_W-1:1]};
    assign w_mid_l = {w_mid[ROW_W-2:0], 1'b0};
    assign w_mid_r = {1'b0, w_mid[ROW_W-1:1]};
    assign w_low_l = {w_low[ROW_W-2:0], 1'b0};
    assign w_low_r = {1'b0, w_low[ROW_W-1:1]};

    always_comb begin
        for (int c = 0; c < ROW_W; c++) begin
            w_cnt[c] = COUNT_W'(w_up_l[c]) + COUNT_W'(w_up[c]) + COUNT_W'(w_up_r[c])
                     + COUNT_W'(w_mid_l[c]) + COUNT_W'(w_mid_r[c])
                     + COUNT_W'(w_low_l[c]) + COUNT_W'(w_low[c]) + COUNT_W'(w_low_r[c]);
            n_cells[c] = i_col_mask[c] && ((w_cnt[c] == BIRTH_COUNT)
                       || ((w_cnt[c] == KEEP_COUNT) && w_mid[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cells <= n_cells;
            r_done  <= i_job.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/life_generation_step_unit.sv]
// Top level of the Life (B3/S23) generation step unit: front, job queue, back.
// Depends on lg_pkg, lg_front, lg_queue and lg_back.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata = row_cells, tlast = final_row
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata = next_cells, tlast = frame_done
// cfg       in   i_cfg_we                       i_cfg_wdata = grid_width
//
// One row is accepted per cycle while the queue has room and no flush is pending;
// after a row with tlast that follows a held row, the front issues the flush of the
// bottom row before it takes the next row. A job enters the queue at the edge its
// row is accepted; the back part loads its result row (all columns in parallel) from the
// queue head once its output register is free. Synchronous active-low reset clears
// the held-row state, the queue and the output register; grid_width resets to 64.
// Either side may stall on its own: the two-entry queue decouples them.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step_unit import lg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [ROW_W-1:0]   s_axis_tdata,   // [63:0] row_cells
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [ROW_W-1:0]        m_axis_tdata,   // [63:0] next_cells
    output logic                    m_axis_tlast,
    input  wire logic               i_cfg_we,
    input  wire logic [WIDTH_W-1:0] i_cfg_wdata
);

    logic [WIDTH_W-1:0] r_grid_width;
    logic [ROW_W-1:0]   w_col_mask;
    logic               w_push, w_push_ready;
    t_job               w_push_job;
    logic               w_job_valid, w_pop;
    t_job               w_job;
    t_front_stat        w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= WIDTH_W'(ROW_W);
        end else if (i_cfg_we) begin
            r_grid_width <= i_cfg_wdata;
        end
    end

    // Widths above the row size saturate by the compare
    always_comb begin
        for (int c = 0; c < ROW_W; c++) begin
            w_col_mask[c] = (WIDTH_W'(c) < r_grid_width);
        end
    end

    lg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_row        (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_push       (w_push),
        .o_job        (w_push_job),
        .i_push_ready (w_push_ready),
        .o_stat       (w_stat)
    );

    lg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_push_job),
        .o_push_ready (w_push_ready),
        .o_valid      (w_job_valid),
        .o_job        (w_job),
        .i_pop        (w_pop)
    );

    lg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_job_valid),
        .i_job      (w_job),
        .o_pop      (w_pop),
        .i_col_mask (w_col_mask),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_cells    (m_axis_tdata),
        .o_done     (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // The front never issues a job the queue cannot take
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_push_ready)
        else $error("job pushed into full queue");

    // After a bottom row, either the frame is closed or its flush is pending
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast)
            |=> (!w_stat.have_mid || w_stat.flush_pend))
        else $error("bottom row left the frame open");

    // A pending flush holds off new rows
    a_flush_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.flush_pend |-> !s_axis_tready)
        else $error("row accepted during flush");

    // No live cell beyond the grid width
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata & ~w_col_mask) == '0))
        else $error("live cell outside grid width");
`endif

endmodule

`default_nettype wire
